// ----- hdl/i2d_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
package i2d_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // Double-dabble correction: a digit of five or more gets three added before the shift.
    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } i2d_state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } i2d_cell_ctl_t;

endpackage

// ----- hdl/i2d_cell.sv -----
// One BCD digit cell of the double-dabble chain; also shifts digits up for output.
module i2d_cell
    import i2d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  i2d_cell_ctl_t ctl,
    input  logic          bit_in,
    input  logic [3:0]    dig_in,
    output logic [3:0]    dig,
    output logic          bit_out
);

    logic [3:0] dig_reg;
    logic [3:0] dig_next;
    logic [3:0] adj;

    assign adj     = (dig_reg >= DABBLE_LIMIT) ? dig_reg + DABBLE_ADD : dig_reg;
    assign bit_out = adj[3];
    assign dig     = dig_reg;

    always_comb
    begin
        dig_next = dig_reg;
        if (ctl.clear)
        begin
            dig_next = 4'd0;
        end
        else if (ctl.dabble)
        begin
            dig_next = {adj[2:0], bit_in};
        end
        else if (ctl.shift)
        begin
            dig_next = dig_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_reg <= 4'd0;
        end
        else
        begin
            dig_reg <= dig_next;
        end
    end

endmodule

// ----- hdl/int32_to_decimal_ascii_top.sv -----
// Top level: sign handling, control sequencer and the chain of digit cells.
// Sequence: one dabble shift per input bit during conversion, then the sign character if the
// value is negative, then one digit shift per digit position, with leading zero digits skipped
// (no strobe) and the units digit always shown. Busy stays high from the accepted start until
// the last digit position has been shifted; a new start is taken only while idle.
// Async reset (rst_n low) idles the sequencer and the strobe.
module int32_to_decimal_ascii_top
    import i2d_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value_bits,
    input  logic                  signed_mode,
    output logic                  strobe,
    output logic [7:0]            char_out,
    output logic                  last_char
);

    localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int CW     = $clog2(VALUE_BITS + 1);
    localparam int DW     = $clog2(DIGITS + 1);

    i2d_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic                  neg_reg, neg_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DW-1:0]         dcnt_reg, dcnt_next;
    logic                  started_reg, started_next;
    logic                  strobe_reg, strobe_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    i2d_cell_ctl_t ctl;
    logic [3:0]    dig [DIGITS];
    logic          carry [DIGITS];
    logic [3:0]    top_dig;
    logic          accept;
    logic          emit;
    logic          in_neg;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign top_dig = dig[DIGITS-1];
    assign emit    = started_reg || (top_dig != 4'd0) || (dcnt_reg == DW'(1));
    assign in_neg  = signed_mode && value_bits[VALUE_BITS-1];

    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                i2d_cell u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .ctl    (ctl),
                    .bit_in (bin_reg[VALUE_BITS-1]),
                    .dig_in (4'd0),
                    .dig    (dig[gi]),
                    .bit_out(carry[gi])
                );
            end
            else
            begin : g_rest
                i2d_cell u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .ctl    (ctl),
                    .bit_in (carry[gi-1]),
                    .dig_in (dig[gi-1]),
                    .dig    (dig[gi]),
                    .bit_out(carry[gi])
                );
            end
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (dcnt_reg == DW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        ctl          = '0;
        bin_next     = bin_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        dcnt_next    = dcnt_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctl.clear    = 1'b1;
                    neg_next     = in_neg;
                    bin_next     = in_neg ? (~value_bits + VALUE_BITS'(1)) : value_bits;
                    cnt_next     = CW'(VALUE_BITS);
                    dcnt_next    = DW'(DIGITS);
                    started_next = 1'b0;
                end
            end
            ST_CONV:
            begin
                ctl.dabble = 1'b1;
                bin_next   = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg - CW'(1);
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = ASCII_MINUS;
                last_next   = 1'b0;
            end
            ST_EMIT:
            begin
                // Drop leading zeros; always show the units digit.
                ctl.shift = 1'b1;
                dcnt_next = dcnt_reg - DW'(1);
                if (emit)
                begin
                    started_next = 1'b1;
                    strobe_next  = 1'b1;
                    char_next    = ASCII_ZERO + {4'd0, top_dig};
                    last_next    = (dcnt_reg == DW'(1));
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            dcnt_reg    <= '0;
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dcnt_reg    <= dcnt_next;
            started_reg <= started_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign strobe    = strobe_reg;
    assign char_out  = char_reg;
    assign last_char = last_reg;

endmodule

// ----- hdl/i2d_checker.sv -----
// Port-level checks for the converter, bound to the top level.
module i2d_checker
    import i2d_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] char_out,
    input logic       last_char
);

    // An accepted start must take the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted start did not raise busy");

    // Characters only come out of work started earlier.
    a_beat_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("character beat without a conversion in flight");

    // The final beat ends the run.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_char |=> !strobe)
        else $error("beat following the last character");

    // More characters pending keeps busy high.
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_char |-> busy)
        else $error("block idle with characters still pending");

    // A minus sign is never the whole text.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (char_out == ASCII_MINUS) |-> !last_char)
        else $error("minus sign marked as last character");

endmodule

bind int32_to_decimal_ascii_top i2d_checker u_i2d_checker (.*);

// ----- tb/tb.sv -----
// Testbench for the binary to decimal ASCII converter: queued command driver and checking monitor.
module tb;
    import i2d_pkg::*;

    localparam int W            = VALUE_BITS_DEF;
    localparam int RANDOM_WORDS = 250;
    localparam int SETTLE       = 2 * W + 24;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [W-1:0] word;
        logic         as_signed;
        logic         drain;
    } conv_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic [W-1:0] value_bits = '0;
    logic         signed_mode = 1'b0;
    logic         busy;
    logic         strobe;
    logic [7:0]   char_out;
    logic         last_char;

    conv_req_t  req_q[$];
    text_beat_t text_q[$];
    bit         failed = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         cycles = 0;

    int32_to_decimal_ascii_top #(.VALUE_BITS(W)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value_bits  (value_bits),
        .signed_mode (signed_mode),
        .strobe      (strobe),
        .char_out    (char_out),
        .last_char   (last_char)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Queue the decimal text of one word, sign first, most significant digit next.
    function automatic void queue_text(input logic [W-1:0] word, input logic as_signed);
        logic [W-1:0] mag;
        logic         neg;
        logic [7:0]   digs[$];
        text_beat_t   b;
        neg = as_signed && word[W-1];
        mag = neg ? (~word + 1'b1) : word;
        if (mag == '0)
        begin
            b.ch = ASCII_ZERO;
            b.last = 1'b1;
            text_q.push_back(b);
            return;
        end
        while (mag != '0)
        begin
            digs.push_front(ASCII_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end
        if (neg)
        begin
            b.ch = ASCII_MINUS;
            b.last = 1'b0;
            text_q.push_back(b);
        end
        foreach (digs[i])
        begin
            b.ch = digs[i];
            b.last = (i == digs.size() - 1);
            text_q.push_back(b);
        end
    endfunction

    function automatic logic [W-1:0] pick_word();
        logic [W-1:0] p;
        int           k;
        p = 1;
        case ($urandom_range(0, 9))
            4: return W'($urandom_range(0, 99));
            5:
            begin
                k = $urandom_range(0, 9);
                repeat (k) p = p * 10;
                return p + W'($urandom_range(0, 2)) - 1'b1;
            end
            6: return -W'($urandom_range(1, 1000));
            7: return {1'b1, {(W-1){1'b0}}} ^ W'($urandom_range(0, 3))
                      ^ ($urandom_range(0, 1) ? '1 : '0);
            8: return W'($urandom) >> $urandom_range(0, W - 1);
            9: return -(W'($urandom) >> $urandom_range(0, W - 1));
            default: return W'($urandom);
        endcase
    endfunction

    function automatic void add_req(input logic [W-1:0] word, input logic as_signed,
                                    input logic drain);
        conv_req_t r;
        r.word = word;
        r.as_signed = as_signed;
        r.drain = drain;
        req_q.push_back(r);
    endfunction

    // Driver: queues the expected text of each accepted start; bursts back to back, random gaps between bursts.
    always @(posedge clk)
    begin
        conv_req_t r;
        if (rst_n)
        begin
            if (start && !busy)
                queue_text(value_bits, signed_mode);
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (req_q.size() == 0)
                start <= 1'b0;
            else if (req_q[0].drain && text_q.size() != 0)
                start <= 1'b0;
            else
            begin
                r = req_q.pop_front();
                value_bits <= r.word;
                signed_mode <= r.as_signed;
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: every strobe is one character beat, checked against the oldest expectation.
    always @(posedge clk)
    begin
        text_beat_t b;
        if (rst_n && strobe)
        begin
            if (text_q.size() == 0)
            begin
                $display("%0t: unexpected char %h last %b", $time, char_out, last_char);
                failed = 1'b1;
            end
            else
            begin
                b = text_q.pop_front();
                if (char_out !== b.ch)
                begin
                    $display("%0t: char_out expected %h got %h", $time, b.ch, char_out);
                    failed = 1'b1;
                end
                if (last_char !== b.last)
                begin
                    $display("%0t: last_char expected %b got %b", $time, b.last, last_char);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [W-1:0] pw;
        // Extremes, both modes, most negative word, zero, powers of ten and their neighbors.
        add_req('0, 1'b0, 1'b0);
        add_req('0, 1'b1, 1'b0);
        add_req(W'(1), 1'b0, 1'b0);
        add_req(W'(9), 1'b1, 1'b0);
        add_req(W'(10), 1'b0, 1'b0);
        add_req('1, 1'b0, 1'b0);
        add_req('1, 1'b1, 1'b0);
        add_req({1'b1, {(W-1){1'b0}}}, 1'b1, 1'b0);
        add_req({1'b1, {(W-1){1'b0}}}, 1'b0, 1'b0);
        add_req({1'b0, {(W-1){1'b1}}}, 1'b1, 1'b0);
        add_req({1'b0, {(W-1){1'b1}}}, 1'b0, 1'b0);
        add_req(W'(1000000000), 1'b0, 1'b0);
        add_req(W'(999999999), 1'b1, 1'b0);
        add_req(-W'(10), 1'b1, 1'b0);
        add_req(-W'(10), 1'b0, 1'b0);
        add_req(W'(32'h5555_5555), 1'b1, 1'b0);
        add_req(W'(32'hAAAA_AAAA), 1'b1, 1'b0);
        add_req(W'(32'hAAAA_AAAA), 1'b0, 1'b0);
        pw = W'(1000000000);
        add_req(pw - 1'b1, 1'b0, 1'b1);
        for (int i = 0; i < RANDOM_WORDS; i++)
            add_req(pick_word(), 1'($urandom), ($urandom_range(0, 49) == 0));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (req_q.size() != 0 || start)
            @(posedge clk);
        while (text_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (text_q.size() != 0)
            failed = 1'b1;
        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/i2d_pkg.sv
hdl/i2d_cell.sv
hdl/int32_to_decimal_ascii_top.sv
hdl/i2d_checker.sv
tb/tb.sv
